// ===== rtl/core/cab565_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and arithmetic helpers for the clipped alpha blit core.
// No dependencies; every other file of the core imports this package.
package cab565_pkg;

	localparam int SCREEN_WIDTH_DEF  = 240;
	localparam int SCREEN_HEIGHT_DEF = 320;

	localparam int POS_W      = 11;   // on-screen coordinate, screen sides up to 2047
	localparam int CNT_W      = 10;   // image column / row counter
	localparam int ORG_W      = 12;   // signed origin register
	localparam int IDX_W      = 17;   // pixel index
	localparam int COLOR_W    = 16;   // RGB565
	localparam int CH_W       = 8;    // one color byte
	localparam int PROD_W     = 2 * POS_W;
	localparam int SUM_W      = 2 * CH_W;

	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam int Q_DEPTH    = 4;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);

	typedef enum logic [1:0] {
		REG_ORIGIN_X,
		REG_ORIGIN_Y,
		REG_IMAGE_WIDTH,
		REG_IMAGE_HEIGHT
	} cfg_reg_t;

	// Classified pixel handed from the front end to the blend pipeline.
	typedef struct packed {
		logic               write_enable;
		logic               last_pixel;
		logic [POS_W-1:0]   pos_x;
		logic [POS_W-1:0]   pos_y;
		logic [CH_W-1:0]    red;
		logic [CH_W-1:0]    green;
		logic [CH_W-1:0]    blue;
		logic [CH_W-1:0]    alpha;
		logic [COLOR_W-1:0] background;
	} item_t;

	// bg*(255-a) + src*a, never above 255*255 so it fits 16 bits.
	function automatic logic [SUM_W-1:0] blend_sum(input logic [CH_W-1:0] bg8,
			input logic [CH_W-1:0] src, input logic [CH_W-1:0] a);
		logic [CH_W-1:0]  inv;
		logic [SUM_W-1:0] p_bg;
		logic [SUM_W-1:0] p_src;
		inv   = ~a;
		p_bg  = bg8 * inv;
		p_src = src * a;
		return p_bg + p_src;
	endfunction

	// floor(x/255) for x <= 65025: (x + 1 + (x >> 8)) >> 8.
	function automatic logic [CH_W-1:0] div255(input logic [SUM_W-1:0] x);
		logic [SUM_W:0] t;
		t = {1'b0, x} + {{SUM_W{1'b0}}, 1'b1} + {{(CH_W+1){1'b0}}, x[SUM_W-1:CH_W]};
		return t[SUM_W-1:CH_W];
	endfunction

	function automatic logic [COLOR_W-1:0] pack565(input logic [CH_W-1:0] r,
			input logic [CH_W-1:0] g, input logic [CH_W-1:0] b);
		return {r[7:3], g[7:2], b[7:3]};
	endfunction

endpackage

// ===== rtl/core/cab565_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces: source pixel stream in, frame buffer writes out.
// Depends on cab565_pkg for field widths.
interface cab565_pix_if import cab565_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [CH_W-1:0]    source_blue;
	logic [CH_W-1:0]    source_green;
	logic [CH_W-1:0]    source_red;
	logic [CH_W-1:0]    source_alpha;
	logic [COLOR_W-1:0] background_pixel;

	modport source (output valid, source_blue, source_green, source_red, source_alpha,
		background_pixel, input ready);
	modport sink (input valid, source_blue, source_green, source_red, source_alpha,
		background_pixel, output ready);
endinterface

interface cab565_res_if import cab565_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               write_enable;
	logic [IDX_W-1:0]   pixel_index;
	logic [COLOR_W-1:0] pixel_color;
	logic               last_pixel;

	modport source (output valid, write_enable, pixel_index, pixel_color, last_pixel,
		input ready);
	modport sink (input valid, write_enable, pixel_index, pixel_color, last_pixel,
		output ready);
endinterface

// ===== rtl/core/clipped_alpha_blit_rgb565_core.sv =====
`timescale 1ns / 1ps
// Clipped alpha blit core, ARGB8888 source over an RGB565 frame buffer.
// Depends on cab565_pkg, cab565_if, cab565_front, cab565_fifo and cab565_back.
//
// Source pixels arrive on pix_in in raster order, one per item, each with the
// frame buffer pixel already under it. Every item yields exactly one item on
// pix_out: a write enable, the frame buffer index row*SCREEN_WIDTH+column
// (17 bits) and the new RGB565 color, plus a flag on the last pixel of the
// image. Pixels off screen or with zero alpha come out with write_enable low
// and zero index and color. Throughput is one item per clock while pix_out is
// ready; an item taken goes into the queue, then into the multiply stage,
// then into the divide/pack stage, which is the output register. The front
// end and the back end are split by a four-entry queue, so pix_in keeps
// taking items while a result waits on pix_out, until the
// queue fills. Config registers (origin_x, origin_y, image_width,
// image_height) sit at byte addresses 0, 4, 8 and 12 of the APB port; write
// them only while no item is in flight. A size of 0 acts as 1. After the last
// pixel the position counters restart, so the next item begins a new image at
// the same origin.
module clipped_alpha_blit_rgb565_core import cab565_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	output logic                  pready,
	cab565_pix_if.sink            pix_in,
	cab565_res_if.source          pix_out
);

	// queue handshake between front and back
	logic  q_push;
	logic  q_full;
	logic  q_pop;
	logic  q_empty;
	item_t q_wr_item;
	item_t q_rd_item;

	// zero wait states
	assign pready = 1'b1;

	cab565_front #(
		.SCREEN_WIDTH  (SCREEN_WIDTH),
		.SCREEN_HEIGHT (SCREEN_HEIGHT)
	) u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pix_in  (pix_in),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_item  (q_wr_item)
	);

	cab565_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_wr_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (q_rd_item),
		.empty     (q_empty)
	);

	// back end stalls only on pix_out.ready
	cab565_back #(
		.SCREEN_WIDTH (SCREEN_WIDTH)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.q_empty (q_empty),
		.q_item  (q_rd_item),
		.q_pop   (q_pop),
		.res_out (pix_out)
	);

endmodule

// ===== rtl/core/cab565_front.sv =====
`timescale 1ns / 1ps
// Front end: config registers, image position counters, clipping and item classification.
// Depends on cab565_pkg and cab565_pix_if.
module cab565_front import cab565_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  psel,
	input  logic                  penable,
	input  logic                  pwrite,
	input  logic [APB_ADDR_W-1:0] paddr,
	input  logic [APB_DATA_W-1:0] pwdata,
	output logic [APB_DATA_W-1:0] prdata,
	cab565_pix_if.sink            pix_in,
	input  logic                  q_full,
	output logic                  q_push,
	output item_t                 q_item
);

	logic [ORG_W-1:0] origin_x_q;
	logic [ORG_W-1:0] origin_y_q;
	logic [CNT_W-1:0] image_width_q;
	logic [CNT_W-1:0] image_height_q;
	logic [CNT_W-1:0] col_q;
	logic [CNT_W-1:0] row_q;

	logic             cfg_wr;
	cfg_reg_t         cfg_sel;
	logic [CNT_W-1:0] w_eff;
	logic [CNT_W-1:0] h_eff;
	logic             col_end;
	logic             row_end;
	logic [ORG_W:0]   sx;
	logic [ORG_W:0]   sy;
	logic             on_screen;

	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_sel = cfg_reg_t'(paddr[APB_ADDR_W-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			origin_x_q     <= '0;
			origin_y_q     <= '0;
			image_width_q  <= CNT_W'(1);
			image_height_q <= CNT_W'(1);
		end else if (cfg_wr) begin
			case (cfg_sel)
				REG_ORIGIN_X:     origin_x_q     <= pwdata[ORG_W-1:0];
				REG_ORIGIN_Y:     origin_y_q     <= pwdata[ORG_W-1:0];
				REG_IMAGE_WIDTH:  image_width_q  <= pwdata[CNT_W-1:0];
				REG_IMAGE_HEIGHT: image_height_q <= pwdata[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_sel)
			REG_ORIGIN_X:     prdata = {{(APB_DATA_W-ORG_W){1'b0}}, origin_x_q};
			REG_ORIGIN_Y:     prdata = {{(APB_DATA_W-ORG_W){1'b0}}, origin_y_q};
			REG_IMAGE_WIDTH:  prdata = {{(APB_DATA_W-CNT_W){1'b0}}, image_width_q};
			REG_IMAGE_HEIGHT: prdata = {{(APB_DATA_W-CNT_W){1'b0}}, image_height_q};
			default:          prdata = '0;
		endcase
	end

	// A size of zero behaves as one; a counter past the end counts as at the end.
	assign w_eff   = (image_width_q == '0) ? CNT_W'(1) : image_width_q;
	assign h_eff   = (image_height_q == '0) ? CNT_W'(1) : image_height_q;
	assign col_end = col_q >= (w_eff - CNT_W'(1));
	assign row_end = row_q >= (h_eff - CNT_W'(1));

	// 13-bit signed screen position, sign in the top bit.
	assign sx = {origin_x_q[ORG_W-1], origin_x_q} + {{(ORG_W+1-CNT_W){1'b0}}, col_q};
	assign sy = {origin_y_q[ORG_W-1], origin_y_q} + {{(ORG_W+1-CNT_W){1'b0}}, row_q};

	assign on_screen = !sx[ORG_W] && (sx[ORG_W-1:0] < ORG_W'(SCREEN_WIDTH))
		&& !sy[ORG_W] && (sy[ORG_W-1:0] < ORG_W'(SCREEN_HEIGHT));

	assign pix_in.ready = !q_full;
	assign q_push       = pix_in.valid && !q_full;

	always_comb begin
		q_item.write_enable = on_screen && (pix_in.source_alpha != '0);
		q_item.last_pixel   = col_end && row_end;
		q_item.pos_x        = sx[POS_W-1:0];
		q_item.pos_y        = sy[POS_W-1:0];
		q_item.red          = pix_in.source_red;
		q_item.green        = pix_in.source_green;
		q_item.blue         = pix_in.source_blue;
		q_item.alpha        = pix_in.source_alpha;
		q_item.background   = pix_in.background_pixel;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (q_push) begin
			if (col_end) begin
				col_q <= '0;
				row_q <= row_end ? '0 : row_q + CNT_W'(1);
			end else begin
				col_q <= col_q + CNT_W'(1);
			end
		end
	end

endmodule

// ===== rtl/core/cab565_fifo.sv =====
`timescale 1ns / 1ps
// Short item queue between the front end and the blend pipeline.
// Depends on cab565_pkg (item_t, Q_DEPTH).
module cab565_fifo import cab565_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  item_t push_item,
	output logic  full,
	input  logic  pop,
	output item_t pop_item,
	output logic  empty
);

	item_t              mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_PTR_W:0]   count_q;

	assign full     = count_q == (Q_PTR_W+1)'(Q_DEPTH);
	assign empty    = count_q == '0;
	assign pop_item = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + (Q_PTR_W+1)'(1);
				2'b01:   count_q <= count_q - (Q_PTR_W+1)'(1);
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/core/cab565_back.sv =====
`timescale 1ns / 1ps
// Back end: two-stage blend and pixel index pipeline; stage two is the output register.
// Depends on cab565_pkg and cab565_res_if.
module cab565_back import cab565_pkg::*; #(
	parameter int SCREEN_WIDTH = SCREEN_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  item_t       q_item,
	output logic        q_pop,
	cab565_res_if.source res_out
);

	logic               adv;
	logic [PROD_W-1:0]  row_prod;

	logic               v_s1;
	logic               we_s1;
	logic               last_s1;
	logic [SUM_W-1:0]   sum_r_s1;
	logic [SUM_W-1:0]   sum_g_s1;
	logic [SUM_W-1:0]   sum_b_s1;
	logic [IDX_W-1:0]   row_base_s1;
	logic [POS_W-1:0]   pos_x_s1;

	logic               v_s2;
	logic               we_s2;
	logic               last_s2;
	logic [IDX_W-1:0]   index_s2;
	logic [COLOR_W-1:0] color_s2;

	assign adv      = !v_s2 || res_out.ready;
	assign q_pop    = adv && !q_empty;
	assign row_prod = q_item.pos_y * POS_W'(SCREEN_WIDTH);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else if (adv) begin
			v_s1 <= !q_empty;
			v_s2 <= v_s1;
		end
	end

	// Stage 1: the multiplies. Full alpha needs no special path: the blend
	// with a = 255 returns the source byte exactly.
	always_ff @(posedge clk) begin
		if (adv) begin
			we_s1       <= q_item.write_enable;
			last_s1     <= q_item.last_pixel;
			sum_r_s1    <= blend_sum({q_item.background[15:11], 3'b000}, q_item.red,
				q_item.alpha);
			sum_g_s1    <= blend_sum({q_item.background[10:5], 2'b00}, q_item.green,
				q_item.alpha);
			sum_b_s1    <= blend_sum({q_item.background[4:0], 3'b000}, q_item.blue,
				q_item.alpha);
			row_base_s1 <= row_prod[IDX_W-1:0];
			pos_x_s1    <= q_item.pos_x;
		end
	end

	// Stage 2: divide by 255, pack, add the column; zero fields when not writing.
	always_ff @(posedge clk) begin
		if (adv) begin
			we_s2    <= we_s1;
			last_s2  <= last_s1;
			index_s2 <= we_s1 ? row_base_s1 + {{(IDX_W-POS_W){1'b0}}, pos_x_s1} : '0;
			color_s2 <= we_s1 ? pack565(div255(sum_r_s1), div255(sum_g_s1),
				div255(sum_b_s1)) : '0;
		end
	end

	assign res_out.valid        = v_s2;
	assign res_out.write_enable = we_s2;
	assign res_out.pixel_index  = index_s2;
	assign res_out.pixel_color  = color_s2;
	assign res_out.last_pixel   = last_s2;

endmodule

// ===== rtl/core/cab565_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks on the result channel of the blit core, bound to the top level.
// Depends on cab565_pkg and clipped_alpha_blit_rgb565_core.
module cab565_checker import cab565_pkg::*; #(
	parameter int SCREEN_WIDTH  = SCREEN_WIDTH_DEF,
	parameter int SCREEN_HEIGHT = SCREEN_HEIGHT_DEF
) (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_ready,
	input logic               write_enable,
	input logic [IDX_W-1:0]   pixel_index,
	input logic [COLOR_W-1:0] pixel_color,
	input logic               last_pixel
);

	localparam longint AREA      = longint'(SCREEN_WIDTH) * longint'(SCREEN_HEIGHT);
	localparam bit     AREA_FITS = AREA <= (longint'(1) << IDX_W);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_payload: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=>
			$stable({write_enable, pixel_index, pixel_color, last_pixel}))
		else $error("result changed while stalled");

	a_no_write_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !write_enable |-> pixel_index == '0 && pixel_color == '0)
		else $error("index or color nonzero on a skipped pixel");

	a_index_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && write_enable |-> !AREA_FITS || longint'(pixel_index) < AREA)
		else $error("pixel index beyond the screen");

endmodule

bind clipped_alpha_blit_rgb565_core cab565_checker #(
	.SCREEN_WIDTH  (SCREEN_WIDTH),
	.SCREEN_HEIGHT (SCREEN_HEIGHT)
) u_cab565_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (pix_out.valid),
	.out_ready    (pix_out.ready),
	.write_enable (pix_out.write_enable),
	.pixel_index  (pix_out.pixel_index),
	.pixel_color  (pix_out.pixel_color),
	.last_pixel   (pix_out.last_pixel)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for clipped_alpha_blit_rgb565_core: random and directed pixel streams.
// Depends on cab565_pkg, cab565_if and the core; predicts every frame buffer write itself.
module tb;
	import cab565_pkg::*;

	localparam int SCREEN_W   = 240;
	localparam int SCREEN_H   = 320;
	localparam int IDLE_LIMIT = 2000;   // cycles with no item moving on either side
	localparam int DRAIN_WAIT = 8;      // idle wait once the two pipeline stages and the 4-entry queue have emptied
	localparam int RAND_ITEMS = 950;

	// one source pixel as it goes in
	typedef struct packed {
		logic [CH_W-1:0]    blue;
		logic [CH_W-1:0]    green;
		logic [CH_W-1:0]    red;
		logic [CH_W-1:0]    alpha;
		logic [COLOR_W-1:0] bg;
	} src_pixel_t;

	// one frame buffer write as it comes out
	typedef struct packed {
		logic               we;
		logic [IDX_W-1:0]   index;
		logic [COLOR_W-1:0] color;
		logic               last;
	} fb_write_t;

	logic                  clk;
	logic                  arst_n;
	logic                  psel;
	logic                  penable;
	logic                  pwrite;
	logic [APB_ADDR_W-1:0] paddr;
	logic [APB_DATA_W-1:0] pwdata;
	logic [APB_DATA_W-1:0] prdata;
	logic                  pready;

	cab565_pix_if px_in ();
	cab565_res_if px_out ();

	clipped_alpha_blit_rgb565_core #(
		.SCREEN_WIDTH  (SCREEN_W),
		.SCREEN_HEIGHT (SCREEN_H)
	) u_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.pix_in  (px_in),
		.pix_out (px_out)
	);

	// shadow of the blit registers and the image position counters
	logic signed [ORG_W-1:0] org_x, org_y;
	logic [CNT_W-1:0]        img_w, img_h;
	logic [CNT_W-1:0]        col_pos, row_pos;

	src_pixel_t pending_px[$];       // pixels waiting to be driven
	fb_write_t  expected_writes[$];  // predicted writes not yet seen

	bit calm;            // phase with no idling on either side
	bit px_taken;        // item taken at the last rising edge
	int send_gap, stall_left;
	int px_sent, px_seen, writes_seen, lasts_seen;
	int mismatches, idle_cycles, settings_run;

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// mostly short gaps, now and then a long one
	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	// truncating blend of one channel
	function automatic logic [CH_W-1:0] mix_channel(logic [CH_W-1:0] bg8, logic [CH_W-1:0] src,
			logic [CH_W-1:0] a);
		int t;
		t = (int'(bg8) * (255 - int'(a)) + int'(src) * int'(a)) / 255;
		return t[CH_W-1:0];
	endfunction

	// expected write for one pixel; steps the position counters
	function automatic fb_write_t predict_blit(src_pixel_t p);
		fb_write_t        r;
		int               w, h, sx, sy;
		bit               col_end, row_end, on_screen;
		logic [CH_W-1:0]  cr, cg, cb;
		w = (img_w == 0) ? 1 : int'(img_w);
		h = (img_h == 0) ? 1 : int'(img_h);
		// a counter past a shrunken size counts as sitting on its last position
		col_end = int'(col_pos) >= w - 1;
		row_end = int'(row_pos) >= h - 1;
		sx = int'(org_x) + int'(col_pos);
		sy = int'(org_y) + int'(row_pos);
		on_screen = sx >= 0 && sx < SCREEN_W && sy >= 0 && sy < SCREEN_H;
		r = '0;
		r.we = on_screen && p.alpha != 0;
		r.last = col_end && row_end;
		if (r.we) begin
			r.index = IDX_W'(sy * SCREEN_W + sx);
			if (p.alpha == 8'hFF) begin
				cr = p.red;
				cg = p.green;
				cb = p.blue;
			end else begin
				// widen 5/6/5 background to bytes with zero low bits
				cr = mix_channel({p.bg[15:11], 3'b000}, p.red, p.alpha);
				cg = mix_channel({p.bg[10:5], 2'b00}, p.green, p.alpha);
				cb = mix_channel({p.bg[4:0], 3'b000}, p.blue, p.alpha);
			end
			r.color = {cr[7:3], cg[7:2], cb[7:3]};
		end
		if (col_end) begin
			col_pos = '0;
			row_pos = row_end ? '0 : row_pos + 1'b1;
		end else begin
			col_pos = col_pos + 1'b1;
		end
		return r;
	endfunction

	// corner pixels: alpha 0, 255, 1, 254 and mid values against extreme colors
	function automatic src_pixel_t corner_pixel(int k);
		src_pixel_t p;
		logic [CH_W-1:0] alphas[6];
		alphas = '{8'd0, 8'd255, 8'd1, 8'd254, 8'd128, 8'd127};
		p.alpha = alphas[k % 6];
		case (k % 4)
			0: begin
				p.red = 8'hFF; p.green = 8'hFF; p.blue = 8'hFF; p.bg = 16'h0000;
			end
			1: begin
				p.red = 8'h00; p.green = 8'h00; p.blue = 8'h00; p.bg = 16'hFFFF;
			end
			2: begin
				p.red = 8'hFF; p.green = 8'h00; p.blue = 8'hFF; p.bg = 16'h07E0;
			end
			default: begin
				p.red = 8'h00; p.green = 8'hFF; p.blue = 8'h00; p.bg = 16'hF81F;
			end
		endcase
		return p;
	endfunction

	function automatic src_pixel_t random_pixel();
		src_pixel_t p;
		int r;
		p = src_pixel_t'({$urandom, $urandom});
		r = $urandom_range(0, 99);
		if (r < 15)
			p.alpha = 8'h00;
		else if (r < 30)
			p.alpha = 8'hFF;
		return p;
	endfunction

	// origin near the screen most of the time, extremes and raw bits otherwise
	function automatic logic [ORG_W-1:0] pick_origin(int span);
		int r, v;
		r = $urandom_range(0, 9);
		if (r == 0) return 12'h800;
		if (r == 1) return 12'h7FF;
		if (r == 2) return ORG_W'($urandom);
		v = int'($urandom_range(0, span + 25)) - 20;
		return ORG_W'(v);
	endfunction

	// small images mostly; zero, full size and raw bits now and then
	function automatic logic [CNT_W-1:0] pick_size();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0) return '0;
		if (r == 1) return 10'd1023;
		if (r == 2) return CNT_W'($urandom);
		return CNT_W'($urandom_range(1, 24));
	endfunction

	// register write, setup then access; the block is idle whenever this runs
	task automatic apb_write(cfg_reg_t r, logic [APB_DATA_W-1:0] v);
		@(negedge clk);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {r, 2'b00};
		pwdata  = v;
		@(negedge clk);
		penable = 1'b1;
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		case (r)
			REG_ORIGIN_X:     org_x = v[ORG_W-1:0];
			REG_ORIGIN_Y:     org_y = v[ORG_W-1:0];
			REG_IMAGE_WIDTH:  img_w = v[CNT_W-1:0];
			REG_IMAGE_HEIGHT: img_h = v[CNT_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_blit(logic [ORG_W-1:0] ox, logic [ORG_W-1:0] oy, logic [CNT_W-1:0] w,
			logic [CNT_W-1:0] h);
		apb_write(REG_ORIGIN_X, APB_DATA_W'(ox));
		apb_write(REG_ORIGIN_Y, APB_DATA_W'(oy));
		apb_write(REG_IMAGE_WIDTH, APB_DATA_W'(w));
		apb_write(REG_IMAGE_HEIGHT, APB_DATA_W'(h));
		settings_run++;
	endtask

	// wait until every pixel has gone through and every write is back
	task automatic drain();
		while (pending_px.size() != 0 || px_in.valid || expected_writes.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
	endtask

	task automatic queue_corner(int n, ref int k);
		repeat (n) begin
			pending_px.push_back(corner_pixel(k));
			k++;
		end
	endtask

	// ---------------------------------------------------------------- sender
	always @(negedge clk) begin
		if (!arst_n) begin
			px_in.valid <= 1'b0;
		end else if (!px_in.valid || px_taken) begin
			px_taken = 1'b0;
			if (send_gap > 0) begin
				send_gap--;
				px_in.valid <= 1'b0;
			end else if (pending_px.size() > 0) begin
				px_in.source_blue      <= pending_px[0].blue;
				px_in.source_green     <= pending_px[0].green;
				px_in.source_red       <= pending_px[0].red;
				px_in.source_alpha     <= pending_px[0].alpha;
				px_in.background_pixel <= pending_px[0].bg;
				px_in.valid            <= 1'b1;
				void'(pending_px.pop_front());
				send_gap = calm ? 0 : pick_gap();
			end else begin
				px_in.valid <= 1'b0;
			end
		end
	end

	// predict at the edge where the pixel is taken
	always @(posedge clk) begin : take_pixel
		src_pixel_t got;
		if (arst_n && px_in.valid && px_in.ready) begin
			got.blue  = px_in.source_blue;
			got.green = px_in.source_green;
			got.red   = px_in.source_red;
			got.alpha = px_in.source_alpha;
			got.bg    = px_in.background_pixel;
			expected_writes.push_back(predict_blit(got));
			px_taken = 1'b1;
			px_sent++;
		end
	end

	// ---------------------------------------------------------------- receiver
	always @(negedge clk) begin
		if (!arst_n) begin
			px_out.ready <= 1'b0;
		end else if (stall_left > 0) begin
			stall_left--;
			px_out.ready <= 1'b0;
		end else begin
			px_out.ready <= 1'b1;
			if (!calm && $urandom_range(0, 3) == 0)
				stall_left = pick_gap();
		end
	end

	always @(posedge clk) begin : check_write
		fb_write_t want;
		bit bad;
		if (arst_n && px_out.valid && px_out.ready) begin
			px_seen++;
			if (px_out.write_enable) writes_seen++;
			if (px_out.last_pixel) lasts_seen++;
			if (expected_writes.size() == 0) begin
				mismatches++;
				$error("write with nothing expected (index %0d)", px_out.pixel_index);
			end else begin
				want = expected_writes.pop_front();
				bad = 1'b0;
				if (px_out.write_enable !== want.we) begin
					bad = 1'b1;
					$error("write_enable: expected %0d, got %0d", want.we,
						px_out.write_enable);
				end
				if (px_out.pixel_index !== want.index) begin
					bad = 1'b1;
					$error("pixel_index: expected %0d, got %0d", want.index,
						px_out.pixel_index);
				end
				if (px_out.pixel_color !== want.color) begin
					bad = 1'b1;
					$error("pixel_color: expected %h, got %h", want.color,
						px_out.pixel_color);
				end
				if (px_out.last_pixel !== want.last) begin
					bad = 1'b1;
					$error("last_pixel: expected %0d, got %0d", want.last,
						px_out.last_pixel);
				end
				if (bad) mismatches++;
			end
		end
	end

	// ---------------------------------------------------------------- watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if ((px_in.valid && px_in.ready) || (px_out.valid && px_out.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no item moved for %0d cycles", IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------- stimulus
	initial begin : stimulus
		int k, n, queued;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		px_in.valid = 1'b0;
		px_in.source_blue = '0;
		px_in.source_green = '0;
		px_in.source_red = '0;
		px_in.source_alpha = '0;
		px_in.background_pixel = '0;
		px_out.ready = 1'b0;
		// reset values of the registers
		org_x = '0;
		org_y = '0;
		img_w = 10'd1;
		img_h = 10'd1;
		col_pos = '0;
		row_pos = '0;
		calm = 1'b0;
		arst_n = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		k = 0;
		// image straddling the right and bottom screen edges
		set_blit(12'd238, 12'd319, 10'd3, 10'd2);
		queue_corner(6, k);
		drain();
		// image hanging off the left and top edges
		set_blit(-12'sd1, -12'sd1, 10'd2, 10'd2);
		queue_corner(4, k);
		drain();
		// stop mid-image, then shrink the size under the counters
		set_blit(12'd0, 12'd0, 10'd4, 10'd4);
		queue_corner(7, k);
		drain();
		set_blit(12'd10, 12'd5, 10'd2, 10'd1);
		queue_corner(2, k);
		drain();
		// zero sizes act as one: every pixel is the last one
		set_blit(12'd100, 12'd100, 10'd0, 10'd0);
		queue_corner(2, k);
		drain();

		// random phases, every fourth one without idling
		queued = 0;
		while (queued < RAND_ITEMS) begin
			calm = (settings_run % 4) == 3;
			set_blit(pick_origin(SCREEN_W), pick_origin(SCREEN_H), pick_size(), pick_size());
			n = $urandom_range(15, 90);
			repeat (n) pending_px.push_back(random_pixel());
			queued += n;
			drain();
		end
		calm = 1'b0;

		if (expected_writes.size() != 0) begin
			mismatches++;
			$error("%0d expected writes never arrived", expected_writes.size());
		end
		$display("Blit run: %0d pixels in, %0d out, over %0d register settings",
			px_sent, px_seen, settings_run);
		$display("Covered %0d frame buffer writes and %0d image ends",
			writes_seen, lasts_seen);
		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule
